// ----- rtl/mfsd_pkg.sv -----
// mfsd_pkg: shared types, codes and constants of the marker framed sum deframer
// used by every module of the block and by the port checker
package mfsd_pkg;

    // defaults of the top level parameters
    localparam int MAX_FRAME_DEF  = 8192;
    localparam int TEXT_LIMIT_DEF = 16;

    localparam logic [7:0] END_MARKER_RST = 8'h04;

    // character codes
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // result field widths
    localparam int IDX_W   = 13;
    localparam int FLEN_W  = 13;
    localparam int SCOMP_W = 21;
    localparam int SRECV_W = 48;

    // checksum magnitude saturates at all ones
    localparam int MAG_W = 47;
    localparam logic [MAG_W-1:0] PARSE_MAX = '1;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        KIND_SKIP     = 3'd0,
        KIND_PAYLOAD  = 3'd1,
        KIND_TEXT     = 3'd2,
        KIND_GOOD     = 3'd3,
        KIND_MISMATCH = 3'd4,
        KIND_TOO_LONG = 3'd5,
        KIND_OVERFLOW = 3'd6
    } kind_t;

    // one classified received byte
    typedef struct packed {
        logic [7:0] data;
        logic       is_crlf;
        logic       is_marker;
        logic       is_zero;
        logic       is_space;
        logic       is_sign;
        logic       is_minus;
        logic       is_digit;
        logic [3:0] digit;
    } item_t;

    // result before the checksum compare
    typedef struct packed {
        logic               verdict;
        kind_t              kind;
        logic [7:0]         data;
        logic [IDX_W-1:0]   idx;
        logic [FLEN_W-1:0]  flen;
        logic [SRECV_W-1:0] sum_wide;
        logic [MAG_W-1:0]   mag;
        logic               neg;
    } res_t;

endpackage

// ----- rtl/mfsd_front.sv -----
// mfsd_front: classifies received bytes and queues them for the frame engine
// depends on mfsd_pkg
module mfsd_front
    import mfsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic [7:0] end_marker,
    input  logic       pop,
    output item_t      head,
    output logic       head_valid
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              push;
    item_t             cls;

    always_comb
    begin
        cls.data      = rx_byte;
        cls.is_crlf   = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
        cls.is_marker = (rx_byte == end_marker);
        cls.is_zero   = (rx_byte == 8'h00);
        cls.is_space  = (rx_byte == CHAR_SPACE) || ((rx_byte >= CHAR_TAB) && (rx_byte <= CHAR_CR));
        cls.is_sign   = (rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS);
        cls.is_minus  = (rx_byte == CHAR_MINUS);
        cls.is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
        cls.digit     = rx_byte[3:0];
    end

    assign in_stall   = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign push       = in_valid && !in_stall;
    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ----- rtl/mfsd_exec.sv -----
// mfsd_exec: frame state, running sum and checksum text parser
// depends on mfsd_pkg; takes classified bytes from mfsd_front
module mfsd_exec
    import mfsd_pkg::*;
#(
    parameter int MAX_FRAME  = MAX_FRAME_DEF,
    parameter int TEXT_LIMIT = TEXT_LIMIT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] end_marker,
    input  item_t      head,
    input  logic       head_valid,
    input  logic       advance,
    output logic       pop,
    output res_t       res,
    output logic       res_valid
);

    localparam int PC_W   = $clog2(MAX_FRAME + 1);
    localparam int SUM_W  = $clog2(MAX_FRAME) + 9;
    localparam int TC_W   = $clog2(TEXT_LIMIT + 2);
    localparam int PROD_W = MAG_W + 4;

    typedef enum logic [1:0] {
        PH_PAYLOAD = 2'b01,
        PH_TEXT    = 2'b10
    } phase_t;

    typedef enum logic [3:0] {
        PS_LEAD   = 4'b0001,
        PS_SIGN   = 4'b0010,
        PS_DIGITS = 4'b0100,
        PS_DONE   = 4'b1000
    } pstage_t;

    phase_t                   phase_reg, phase_next;
    logic [PC_W-1:0]          pc_reg, pc_next;
    logic [TC_W-1:0]          tc_reg, tc_next;
    logic [7:0]               prev_reg, prev_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [PC_W-1:0]          cl_reg, cl_next;
    logic                     zero_reg, zero_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    pstage_t                  stage_reg, stage_next;
    logic                     neg_reg, neg_next;
    logic                     res_valid_reg;
    res_t                     res_reg, res_next;

    logic [PROD_W-1:0]        prod;
    logic [MAG_W-1:0]         add_mag;
    logic [MAG_W-1:0]         mag_par;
    pstage_t                  stage_par;
    logic                     neg_par;
    logic [TC_W-1:0]          tc_inc;
    logic [PC_W-1:0]          flen_raw;
    logic [IDX_W+PC_W-1:0]    idx_ext;
    logic [FLEN_W+PC_W-1:0]   flen_ext;
    logic                     marker_pair;

    assign pop       = head_valid && advance;
    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    assign marker_pair = (prev_reg == end_marker) && head.is_marker;
    assign tc_inc      = tc_reg + 1'b1;
    assign flen_raw    = (cl_reg >= PC_W'(2)) ? cl_reg - PC_W'(2) : '0;
    assign idx_ext     = {{IDX_W{1'b0}}, pc_reg};
    assign flen_ext    = {{FLEN_W{1'b0}}, flen_raw};

    // mag * 10 + digit, saturating
    assign prod    = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1) + PROD_W'(head.digit);
    assign add_mag = (prod > PROD_W'(PARSE_MAX)) ? PARSE_MAX : prod[MAG_W-1:0];

    always_comb
    begin
        mag_par   = mag_reg;
        stage_par = stage_reg;
        neg_par   = neg_reg;
        unique case (stage_reg)
            PS_LEAD:
            begin
                if (!head.is_space)
                begin
                    priority if (head.is_sign)
                    begin
                        neg_par   = head.is_minus;
                        stage_par = PS_SIGN;
                    end
                    else if (head.is_digit)
                    begin
                        mag_par   = add_mag;
                        stage_par = PS_DIGITS;
                    end
                    else
                    begin
                        stage_par = PS_DONE;
                    end
                end
            end
            PS_SIGN, PS_DIGITS:
            begin
                if (head.is_digit)
                begin
                    mag_par   = add_mag;
                    stage_par = PS_DIGITS;
                end
                else
                begin
                    stage_par = PS_DONE;
                end
            end
            PS_DONE:
            begin
                stage_par = PS_DONE;
            end
            default:
            begin
                stage_par = PS_DONE;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        pc_next    = pc_reg;
        tc_next    = tc_reg;
        prev_next  = prev_reg;
        sum_next   = sum_reg;
        cl_next    = cl_reg;
        zero_next  = zero_reg;
        mag_next   = mag_reg;
        stage_next = stage_reg;
        neg_next   = neg_reg;

        res_next          = '0;
        res_next.kind     = KIND_SKIP;

        if (pop)
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    priority if ((pc_reg == '0) && head.is_crlf)
                    begin
                        res_next.kind = KIND_SKIP;
                    end
                    else if (pc_reg == PC_W'(MAX_FRAME))
                    begin
                        res_next.kind = KIND_OVERFLOW;
                        pc_next   = '0;
                        tc_next   = '0;
                        prev_next = '0;
                        sum_next  = '0;
                        cl_next   = '0;
                        zero_next = 1'b0;
                    end
                    else
                    begin
                        // sum and length freeze at the first zero byte
                        if (!zero_reg)
                        begin
                            if (head.is_zero)
                            begin
                                zero_next = 1'b1;
                            end
                            else
                            begin
                                sum_next = sum_reg + SUM_W'(signed'(head.data));
                                cl_next  = cl_reg + 1'b1;
                            end
                        end
                        res_next.kind = KIND_PAYLOAD;
                        res_next.data = head.data;
                        res_next.idx  = idx_ext[IDX_W-1:0];
                        pc_next       = pc_reg + 1'b1;
                        prev_next     = head.data;
                        if ((pc_reg >= PC_W'(2)) && marker_pair)
                        begin
                            phase_next = PH_TEXT;
                            tc_next    = '0;
                            mag_next   = '0;
                            stage_next = PS_LEAD;
                            neg_next   = 1'b0;
                        end
                    end
                end
                PH_TEXT:
                begin
                    if (tc_inc > TC_W'(TEXT_LIMIT))
                    begin
                        res_next.kind = KIND_TOO_LONG;
                        phase_next = PH_PAYLOAD;
                        pc_next    = '0;
                        tc_next    = '0;
                        prev_next  = '0;
                        sum_next   = '0;
                        cl_next    = '0;
                        zero_next  = 1'b0;
                        mag_next   = '0;
                        stage_next = PS_LEAD;
                        neg_next   = 1'b0;
                    end
                    else if ((tc_inc > TC_W'(2)) && marker_pair)
                    begin
                        // closing marker still goes through the parser
                        res_next.verdict  = 1'b1;
                        res_next.kind     = KIND_GOOD;
                        res_next.flen     = flen_ext[FLEN_W-1:0];
                        res_next.sum_wide = SRECV_W'(sum_reg);
                        res_next.mag      = mag_par;
                        res_next.neg      = neg_par;
                        phase_next = PH_PAYLOAD;
                        pc_next    = '0;
                        tc_next    = '0;
                        prev_next  = '0;
                        sum_next   = '0;
                        cl_next    = '0;
                        zero_next  = 1'b0;
                        mag_next   = '0;
                        stage_next = PS_LEAD;
                        neg_next   = 1'b0;
                    end
                    else
                    begin
                        res_next.kind = KIND_TEXT;
                        res_next.data = head.data;
                        tc_next    = tc_inc;
                        prev_next  = head.data;
                        mag_next   = mag_par;
                        stage_next = stage_par;
                        neg_next   = neg_par;
                    end
                end
                default:
                begin
                    phase_next = PH_PAYLOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PAYLOAD;
            pc_reg        <= '0;
            tc_reg        <= '0;
            prev_reg      <= '0;
            sum_reg       <= '0;
            cl_reg        <= '0;
            zero_reg      <= 1'b0;
            mag_reg       <= '0;
            stage_reg     <= PS_LEAD;
            neg_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pc_reg    <= pc_next;
            tc_reg    <= tc_next;
            prev_reg  <= prev_next;
            sum_reg   <= sum_next;
            cl_reg    <= cl_next;
            zero_reg  <= zero_next;
            mag_reg   <= mag_next;
            stage_reg <= stage_next;
            neg_reg   <= neg_next;
            if (advance)
            begin
                res_valid_reg <= head_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- rtl/mfsd_report.sv -----
// mfsd_report: checksum compare and the output register of the result channel
// depends on mfsd_pkg; takes results from mfsd_exec
module mfsd_report
    import mfsd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  res_t                      res,
    input  logic                      res_valid,
    output logic                      advance,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                kind,
    output logic [7:0]                data_byte,
    output logic [IDX_W-1:0]          byte_index,
    output logic [FLEN_W-1:0]         frame_length,
    output logic signed [SCOMP_W-1:0] sum_computed,
    output logic signed [SRECV_W-1:0] sum_received
);

    logic                      out_valid_reg;
    logic [2:0]                kind_reg;
    logic [7:0]                data_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [FLEN_W-1:0]         flen_reg;
    logic signed [SCOMP_W-1:0] scomp_reg;
    logic signed [SRECV_W-1:0] srecv_reg;

    logic [SRECV_W-1:0]        mag_ext;
    logic [SRECV_W-1:0]        value;
    kind_t                     kind_fin;

    assign advance = !out_valid_reg || !out_stall;

    assign mag_ext  = {1'b0, res.mag};
    assign value    = res.neg ? (SRECV_W'(0) - mag_ext) : mag_ext;
    assign kind_fin = !res.verdict ? res.kind :
                      (value == res.sum_wide) ? KIND_GOOD : KIND_MISMATCH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            kind_reg  <= kind_fin;
            data_reg  <= res.data;
            idx_reg   <= res.idx;
            if (res.verdict)
            begin
                flen_reg  <= res.flen;
                scomp_reg <= res.sum_wide[SCOMP_W-1:0];
                srecv_reg <= value;
            end
            else
            begin
                flen_reg  <= '0;
                scomp_reg <= '0;
                srecv_reg <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign data_byte    = data_reg;
    assign byte_index   = idx_reg;
    assign frame_length = flen_reg;
    assign sum_computed = scomp_reg;
    assign sum_received = srecv_reg;

endmodule

// ----- rtl/marker_framed_sum_deframer.sv -----
// marker_framed_sum_deframer: top level, end marker register and the three stages
// depends on mfsd_pkg, mfsd_front, mfsd_exec, mfsd_report
//
//  channel   direction  handshake              payload
//  in        to block   in_valid / in_stall    rx_byte
//  out       from block out_valid / out_stall  kind, data_byte, byte_index, frame_length,
//                                              sum_computed, sum_received
//  cfg       to block   cfg_valid / cfg_ready  cfg_data (end marker, always ready)
//
// one byte per cycle sustained while out_stall is low; a byte's result passes the queue,
// the frame engine register, then the output register
// reset clears the frame state, queue and output valid; end marker returns to 0x04
// out_stall holds the frame engine and output register; the two entry queue keeps
// taking bytes until full, then raises in_stall
module marker_framed_sum_deframer
    import mfsd_pkg::*;
#(
    parameter int MAX_FRAME  = MAX_FRAME_DEF,
    parameter int TEXT_LIMIT = TEXT_LIMIT_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                rx_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                kind,
    output logic [7:0]                data_byte,
    output logic [IDX_W-1:0]          byte_index,
    output logic [FLEN_W-1:0]         frame_length,
    output logic signed [SCOMP_W-1:0] sum_computed,
    output logic signed [SRECV_W-1:0] sum_received,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [7:0]                cfg_data
);

    logic [7:0] end_marker_reg;
    item_t      head;
    logic       head_valid;
    logic       pop;
    logic       advance;
    res_t       res;
    logic       res_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_marker_reg <= END_MARKER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            end_marker_reg <= cfg_data;
        end
    end

    mfsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .end_marker (end_marker_reg),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    mfsd_exec #(
        .MAX_FRAME  (MAX_FRAME),
        .TEXT_LIMIT (TEXT_LIMIT)
    ) u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .end_marker (end_marker_reg),
        .head       (head),
        .head_valid (head_valid),
        .advance    (advance),
        .pop        (pop),
        .res        (res),
        .res_valid  (res_valid)
    );

    mfsd_report u_report (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (res),
        .res_valid    (res_valid),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .byte_index   (byte_index),
        .frame_length (frame_length),
        .sum_computed (sum_computed),
        .sum_received (sum_received)
    );

endmodule

// ----- rtl/mfsd_checker.sv -----
// mfsd_checker: port level assertions on the result channel of the deframer
// depends on mfsd_pkg; bound to marker_framed_sum_deframer
module mfsd_checker
    import mfsd_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [2:0]                kind,
    input logic [7:0]                data_byte,
    input logic [IDX_W-1:0]          byte_index,
    input logic [FLEN_W-1:0]         frame_length,
    input logic signed [SCOMP_W-1:0] sum_computed,
    input logic signed [SRECV_W-1:0] sum_received
);

    // a stalled result holds until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
            && $stable(byte_index) && $stable(sum_received))
        else $error("stalled result changed");

    // a good frame reports matching sums
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_GOOD) |-> sum_received[SCOMP_W-1:0] == sum_computed)
        else $error("good verdict with differing sums");

    // only verdicts carry length and sums
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_GOOD) && (kind != KIND_MISMATCH)
            |-> (frame_length == '0) && (sum_computed == '0) && (sum_received == '0))
        else $error("verdict fields set on a non-verdict result");

    // only payload and checksum characters echo the byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_PAYLOAD) && (kind != KIND_TEXT) |-> data_byte == 8'h00)
        else $error("byte echoed on a result that has none");

endmodule

bind marker_framed_sum_deframer mfsd_checker u_mfsd_checker (.*);

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for the marker framed sum deframer, byte stream in, one result out
// depends on mfsd_pkg and marker_framed_sum_deframer; holds its own deframer predictor
`timescale 1ns / 100ps

module tb_top;
    import mfsd_pkg::*;

    localparam longint unsigned MAG_LIMIT = PARSE_MAX;

    typedef enum logic [1:0] {
        PARSE_WS,
        PARSE_SIGN,
        PARSE_DIGITS,
        PARSE_DONE
    } parse_stage_t;

    typedef struct {
        kind_t                      kind;
        logic [7:0]                 data;
        logic [IDX_W-1:0]           idx;
        logic [FLEN_W-1:0]          flen;
        logic signed [SCOMP_W-1:0]  scomp;
        logic signed [SRECV_W-1:0]  srecv;
    } frame_result_t;

    class deframe_scoreboard;
        logic [7:0]        marker;
        bit                in_text;
        int                payload_cnt;
        int                text_cnt;
        logic [7:0]        prev_byte;
        longint            run_sum;
        int                length_cnt;
        bit                zero_hit;
        longint unsigned   magnitude;
        parse_stage_t      stage;
        bit                is_neg;
        frame_result_t     pending_q[$];
        int                errors;

        function new();
            marker = END_MARKER_RST;
            errors = 0;
            clear_frame();
            clear_parse();
        endfunction

        function void clear_frame();
            in_text = 0;
            payload_cnt = 0;
            text_cnt = 0;
            prev_byte = 8'h00;
            run_sum = 0;
            length_cnt = 0;
            zero_hit = 0;
        endfunction

        function void clear_parse();
            magnitude = 0;
            stage = PARSE_WS;
            is_neg = 0;
        endfunction

        function bit at_frame_start();
            return !in_text && payload_cnt == 0;
        endfunction

        function void add_digit(longint unsigned d);
            // magnitude saturates instead of wrapping
            if (magnitude > (MAG_LIMIT - d) / 10)
                magnitude = MAG_LIMIT;
            else
                magnitude = magnitude * 10 + d;
        endfunction

        function void parse_char(logic [7:0] c);
            bit is_digit;
            is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
            case (stage)
                PARSE_WS:
                begin
                    if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
                        return;
                    else if (c == CHAR_PLUS || c == CHAR_MINUS)
                    begin
                        is_neg = (c == CHAR_MINUS);
                        stage = PARSE_SIGN;
                    end
                    else if (is_digit)
                    begin
                        add_digit(64'(c - CHAR_ZERO));
                        stage = PARSE_DIGITS;
                    end
                    else
                        stage = PARSE_DONE;
                end
                PARSE_SIGN, PARSE_DIGITS:
                begin
                    if (is_digit)
                    begin
                        add_digit(64'(c - CHAR_ZERO));
                        stage = PARSE_DIGITS;
                    end
                    else
                        stage = PARSE_DONE;
                end
                default:
                    ;
            endcase
        endfunction

        // predict the result of one accepted byte
        function void note_byte(logic [7:0] b);
            frame_result_t r;
            bit closing;
            longint value;
            r.kind = KIND_SKIP;
            r.data = '0;
            r.idx = '0;
            r.flen = '0;
            r.scomp = '0;
            r.srecv = '0;
            if (!in_text)
            begin
                if (payload_cnt == 0 && (b == CHAR_CR || b == CHAR_LF))
                    r.kind = KIND_SKIP;
                else if (payload_cnt >= MAX_FRAME_DEF)
                begin
                    clear_frame();
                    r.kind = KIND_OVERFLOW;
                end
                else
                begin
                    closing = payload_cnt >= 2 && prev_byte == marker && b == marker;
                    // sum and length freeze at the first zero byte
                    if (!zero_hit)
                    begin
                        if (b == 8'h00)
                            zero_hit = 1;
                        else
                        begin
                            run_sum += longint'($signed(b));
                            length_cnt++;
                        end
                    end
                    r.kind = KIND_PAYLOAD;
                    r.data = b;
                    r.idx = payload_cnt[IDX_W-1:0];
                    payload_cnt++;
                    prev_byte = b;
                    if (closing)
                    begin
                        in_text = 1;
                        text_cnt = 0;
                        clear_parse();
                    end
                end
            end
            else
            begin
                text_cnt++;
                if (text_cnt > TEXT_LIMIT_DEF)
                begin
                    clear_frame();
                    clear_parse();
                    r.kind = KIND_TOO_LONG;
                end
                else
                begin
                    closing = text_cnt > 2 && prev_byte == marker && b == marker;
                    parse_char(b);
                    prev_byte = b;
                    if (closing)
                    begin
                        value = is_neg ? -longint'(magnitude) : longint'(magnitude);
                        r.kind = (value == run_sum) ? KIND_GOOD : KIND_MISMATCH;
                        r.flen = (length_cnt >= 2) ? FLEN_W'(length_cnt - 2) : '0;
                        r.scomp = run_sum[SCOMP_W-1:0];
                        r.srecv = value[SRECV_W-1:0];
                        clear_frame();
                        clear_parse();
                    end
                    else
                    begin
                        r.kind = KIND_TEXT;
                        r.data = b;
                    end
                end
            end
            pending_q.insert(pending_q.size(), r);
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t want;
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("error: result with nothing expected, kind %0d data %h",
                             got.kind, got.data);
                return;
            end
            want = pending_q.pop_front();
            if (got.kind !== want.kind || got.data !== want.data || got.idx !== want.idx ||
                got.flen !== want.flen || got.scomp !== want.scomp ||
                got.srecv !== want.srecv)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("error: expected kind %0d data %h idx %0d len %0d sum %0d rcv %0d",
                             want.kind, want.data, want.idx, want.flen, want.scomp,
                             want.srecv);
                    $display("       actual   kind %0d data %h idx %0d len %0d sum %0d rcv %0d",
                             got.kind, got.data, got.idx, got.flen, got.scomp, got.srecv);
                end
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [7:0]                 rx_byte = 8'h00;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [2:0]                 kind;
    logic [7:0]                 data_byte;
    logic [IDX_W-1:0]           byte_index;
    logic [FLEN_W-1:0]          frame_length;
    logic signed [SCOMP_W-1:0]  sum_computed;
    logic signed [SRECV_W-1:0]  sum_received;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [7:0]                 cfg_data = 8'h00;

    int idle_pct = 0;
    int stall_pct = 0;
    int sent_count = 0;
    deframe_scoreboard sb;

    marker_framed_sum_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .byte_index   (byte_index),
        .frame_length (frame_length),
        .sum_computed (sum_computed),
        .sum_received (sum_received),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // values read right after the edge are the ones the transfer used
    always @(posedge clk)
    begin : result_monitor
        frame_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind = kind_t'(kind);
            got.data = data_byte;
            got.idx = byte_index;
            got.flen = frame_length;
            got.scomp = sum_computed;
            got.srecv = sum_received;
            sb.check_result(got);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b);
        sent_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_marker(input logic [7:0] v);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.marker = v;
    endtask

    function automatic logic [7:0] non_marker_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == sb.marker);
        return b;
    endfunction

    task automatic send_markers();
        send_byte(sb.marker);
        send_byte(sb.marker);
    endtask

    // push the frame state back to the start: payload ends on markers, text runs out
    task automatic resync();
        while (!sb.at_frame_start())
            send_byte(sb.in_text ? (sb.marker ^ 8'h01) : sb.marker);
    endtask

    task automatic send_payload(input int n, input int zero_pct);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            do
            begin
                b = 8'($urandom_range(255));
                if ($urandom_range(99) < zero_pct)
                    b = 8'h00;
            end
            while (b == sb.marker || (i == 0 && (b == CHAR_CR || b == CHAR_LF)));
            send_byte(b);
        end
        send_markers();
    endtask

    task automatic send_checksum(input longint value, input bit with_plus, input int ws);
        string digits;
        repeat (ws)
            send_byte($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
        if (value < 0)
            send_byte(CHAR_MINUS);
        else if (with_plus)
            send_byte(CHAR_PLUS);
        digits = $sformatf("%0d", (value < 0) ? -value : value);
        for (int k = 0; k < digits.len(); k++)
            send_byte(digits[k]);
        send_markers();
    endtask

    task automatic send_chars(input string s);
        for (int k = 0; k < s.len(); k++)
            send_byte(s[k]);
    endtask

    task automatic directed_frames();
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        // both signed extremes, plus sign and leading whitespace
        send_byte(8'h41);
        send_byte(8'h80);
        send_byte(8'h7f);
        send_byte(8'hff);
        send_markers();
        send_checksum(sb.run_sum, 1, 2);
        // negative checksum
        send_byte(8'h80);
        send_byte(8'h80);
        send_markers();
        send_checksum(sb.run_sum, 0, 0);
        // mismatch
        send_byte(8'h01);
        send_markers();
        send_checksum(sb.run_sum + 1, 0, 1);
        // zero byte stops sum and length
        send_byte(8'h05);
        send_byte(8'h00);
        send_byte(8'h33);
        send_markers();
        send_checksum(sb.run_sum, 0, 0);
        // frame of markers only, then a text that is not a number
        send_markers();
        send_byte(sb.marker);
        send_chars("x");
        send_markers();
        // text too long even though the 17th char would close it
        send_byte(8'h10);
        send_markers();
        send_chars("111111111111111");
        send_markers();
    endtask

    // digit marker lets the text run past the saturation point
    task automatic saturating_frames();
        send_byte(8'h10);
        send_markers();
        send_chars("1919191919191");
        send_markers();
        send_byte(8'h22);
        send_markers();
        send_chars("-191919191919");
        send_markers();
    endtask

    task automatic random_traffic(input int budget);
        int start;
        int pick;
        int n;
        start = sent_count;
        while (sent_count - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                resync();
                repeat ($urandom_range(2))
                    send_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
                n = ($urandom_range(19) == 0) ? $urandom_range(300, 40) : $urandom_range(12, 1);
                send_payload(n, ($urandom_range(9) == 0) ? 5 : 0);
                send_checksum(sb.run_sum + (($urandom_range(4) == 0) ? $urandom_range(3, 1) : 0),
                              1'($urandom_range(1)), $urandom_range(2));
            end
            else if (pick < 75)
            begin
                resync();
                send_payload($urandom_range(4, 1), 0);
                repeat (TEXT_LIMIT_DEF + 1)
                    send_byte(non_marker_byte());
            end
            else if (pick < 87)
            begin
                repeat ($urandom_range(8, 1))
                    send_byte(8'($urandom_range(255)));
            end
            else
            begin
                resync();
                send_payload($urandom_range(6, 1), 10);
                repeat ($urandom_range(6, 1))
                    send_byte(8'($urandom_range(255)));
                send_markers();
            end
            if ($urandom_range(24) == 0)
                drain();
        end
    endtask

    logic [7:0] phase_marker[4] = '{8'hff, 8'h39, 8'h00, 8'h0d};
    int         phase_idle[4]   = '{0, 48, 0, 20};
    int         phase_stall[4]  = '{0, 0, 48, 20};

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_frames();
        for (int p = 0; p < 4; p++)
        begin
            write_marker(phase_marker[p]);
            idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            if (phase_marker[p] == 8'h39)
                saturating_frames();
            random_traffic(250);
        end
        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
